@@ hw/rtl/msr_pkg.sv @@
// Shared widths, limits and the request record for the modular square root unit.
// No dependencies.
`default_nettype none
package msr_pkg;
  localparam int unsigned ModulusBits = 32;
  localparam int unsigned CntBits = $clog2(ModulusBits) + 1;
  localparam int unsigned SearchLimit = 1024;
  localparam int unsigned TriedBits = $clog2(SearchLimit) + 1;

  typedef logic [ModulusBits-1:0] word_t;

  // Request for init * base^exp mod p
  typedef struct packed {
    word_t init;
    word_t base;
    word_t expo;
  } pow_req_t;
endpackage
`default_nettype wire

@@ hw/rtl/msr_modmul.sv @@
// Bit-serial modular multiplier: a * b mod p, one bit of b per cycle.
// Depends on msr_pkg.
`default_nettype none
module msr_modmul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire msr_pkg::word_t a_i,
  input  wire msr_pkg::word_t b_i,
  input  wire msr_pkg::word_t p_i,
  output logic               done_o,
  output msr_pkg::word_t     res_o
);
  import msr_pkg::*;

  function automatic word_t add_mod(word_t a, word_t b, word_t p);
    word_t gap;
    gap = p - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  logic  run_q;
  word_t a_q, b_q, acc_q;

  assign done_o = run_q && (b_q == '0);
  assign res_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= add_mod(acc_q, a_q, p_i);
      end
      a_q <= add_mod(a_q, a_q, p_i);
      b_q <= b_q >> 1;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/msr_pow.sv @@
// Square-and-multiply sequencer: init * base^exp mod p over the shared multiplier.
// Depends on msr_pkg and msr_modmul.
`default_nettype none
module msr_pow (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire msr_pkg::pow_req_t req_i,
  input  wire msr_pkg::word_t    p_i,
  output logic                  done_o,
  output msr_pkg::word_t        res_o
);
  import msr_pkg::*;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_STEP = 4'b0010,
    P_ACC  = 4'b0100,
    P_SQR  = 4'b1000
  } pstate_e;

  pstate_e state_q, state_d;
  word_t   acc_q, base_q, e_q;
  logic    mm_start, mm_done, use_acc;
  word_t   mm_a, mm_res;

  msr_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (base_q),
    .p_i    (p_i),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign mm_a   = use_acc ? acc_q : base_q;
  assign res_o  = acc_q;

  always_comb begin
    state_d  = state_q;
    mm_start = 1'b0;
    use_acc  = 1'b0;
    done_o   = 1'b0;
    unique case (state_q)
      P_IDLE: begin
        if (start_i) state_d = P_STEP;
      end
      P_STEP: begin
        if (e_q == '0) begin
          done_o  = 1'b1;
          state_d = P_IDLE;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          use_acc  = 1'b1;
          state_d  = P_ACC;
        end else begin
          mm_start = 1'b1;
          state_d  = P_SQR;
        end
      end
      P_ACC: begin
        if (mm_done) begin
          if ((e_q >> 1) == '0) begin
            state_d = P_STEP;
          end else begin
            mm_start = 1'b1;
            state_d  = P_SQR;
          end
        end
      end
      P_SQR: begin
        if (mm_done) state_d = P_STEP;
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == P_IDLE && start_i) begin
      acc_q  <= req_i.init;
      base_q <= req_i.base;
      e_q    <= req_i.expo;
    end else if (state_q == P_ACC && mm_done) begin
      acc_q <= mm_res;
      if ((e_q >> 1) == '0) e_q <= '0;
    end else if (state_q == P_SQR && mm_done) begin
      base_q <= mm_res;
      e_q    <= e_q >> 1;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/modular_square_root_unit.sv @@
// Top level: stream ports, value reduction and the Tonelli-Shanks sequencer.
// Depends on msr_pkg and msr_pow.
//
// Returns a square root of value modulo a prime modulus and a flag that tells whether one
// exists. One item is worked at a time; the input is ready again once the result is held in
// the output register. The time an item takes is data dependent: the reduction comes first,
// then every modular multiply runs in the bit-serial multiplier, and an exponentiation takes
// up to 63 multiplies. Tonelli-Shanks adds one exponentiation per candidate in the
// non-residue search, three more for the correction factor and the two starting values,
// plus the squaring loop. All of these run on the one shared multiplier.
`default_nettype none
module modular_square_root_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // value [31:0], modulus [63:32]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // root [31:0]
  output logic             m_axis_tuser_o   // has_root [0]
);
  import msr_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_RED  = 17'h00002, S_EUL  = 17'h00004, S_P34  = 17'h00008,
    S_FACT = 17'h00010, S_SRCH = 17'h00020, S_ZPOW = 17'h00040, S_CPOW = 17'h00080,
    S_TPOW = 17'h00100, S_RPOW = 17'h00200, S_LOOP = 17'h00400, S_SQ   = 17'h00800,
    S_CSQ  = 17'h01000, S_CC   = 17'h02000, S_CT   = 17'h04000, S_CR   = 17'h08000,
    S_FIN  = 17'h10000
  } state_e;

  state_e   state_q;
  word_t    n_q, p_q, dvd_q, q_q, z_q, c_q, t_q, r_q, b_q, root_q;
  logic [CntBits-1:0]   cnt_q, s_q, m_q, i_q, j_q;
  logic [TriedBits-1:0] tried_q;
  logic     ok_q, wait_q, out_v_q, out_ok_q;
  word_t    out_root_q;

  pow_req_t req;
  logic     pw_start, pw_done, need;
  word_t    pw_res, half, tmp_rem;
  logic [ModulusBits:0] tmp;
  logic     is_call;

  msr_pow u_pow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pw_start),
    .req_i  (req),
    .p_i    (p_q),
    .done_o (pw_done),
    .res_o  (pw_res)
  );

  assign half = (p_q - word_t'(1)) >> 1;
  assign tmp  = {n_q, dvd_q[ModulusBits-1]};
  assign tmp_rem = (tmp >= {1'b0, p_q}) ? word_t'(tmp - {1'b0, p_q}) : word_t'(tmp);

  always_comb begin
    req     = '{init: word_t'(1), base: n_q, expo: half};
    need    = 1'b1;
    is_call = 1'b1;
    unique case (state_q)
      S_EUL:  req = '{init: word_t'(1), base: n_q, expo: half};
      S_P34:  req = '{init: word_t'(1), base: n_q, expo: (p_q >> 2) + word_t'(1)};
      S_ZPOW: req = '{init: word_t'(1), base: z_q, expo: half};
      S_CPOW: req = '{init: word_t'(1), base: z_q, expo: q_q};
      S_TPOW: req = '{init: word_t'(1), base: n_q, expo: q_q};
      S_RPOW: req = '{init: word_t'(1), base: n_q, expo: (q_q >> 1) + word_t'(1)};
      S_SQ: begin
        req  = '{init: b_q, base: b_q, expo: word_t'(1)};
        need = (b_q != word_t'(1));
      end
      S_CSQ: begin
        req  = '{init: b_q, base: b_q, expo: word_t'(1)};
        need = ({1'b0, j_q} + {1'b0, i_q} + (CntBits+1)'(1)) < {1'b0, m_q};
      end
      S_CC:   req = '{init: b_q, base: b_q, expo: word_t'(1)};
      S_CT:   req = '{init: t_q, base: c_q, expo: word_t'(1)};
      S_CR:   req = '{init: r_q, base: b_q, expo: word_t'(1)};
      default: is_call = 1'b0;
    endcase
    pw_start = is_call && !wait_q && need;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_root_q;
  assign m_axis_tuser_o  = out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pw_start) wait_q <= 1'b1;
      else if (pw_done) wait_q <= 1'b0;
      if (state_q == S_FIN && (!out_v_q || m_axis_tready_i)) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            if (s_axis_tdata_i[63:32] < 32'd2) state_q <= S_FIN;
            else if (s_axis_tdata_i[63:32] == 32'd2) state_q <= S_FIN;
            else state_q <= S_RED;
          end
        end
        S_RED: begin
          if (cnt_q == CntBits'(ModulusBits - 1)) begin
            state_q <= (tmp_rem == '0) ? S_FIN : S_EUL;
          end
        end
        S_EUL: begin
          if (pw_done) begin
            if (pw_res != word_t'(1)) state_q <= S_FIN;
            else if (p_q[1:0] == 2'b11) state_q <= S_P34;
            else state_q <= S_FACT;
          end
        end
        S_P34:  if (pw_done) state_q <= S_FIN;
        S_FACT: if (q_q[0]) state_q <= S_SRCH;
        S_SRCH: begin
          state_q <= (z_q < p_q && tried_q < TriedBits'(SearchLimit)) ? S_ZPOW : S_TPOW;
        end
        S_ZPOW: if (pw_done) state_q <= (pw_res == p_q - word_t'(1)) ? S_CPOW : S_SRCH;
        S_CPOW: if (pw_done) state_q <= S_TPOW;
        S_TPOW: if (pw_done) state_q <= S_RPOW;
        S_RPOW: if (pw_done) state_q <= S_LOOP;
        S_LOOP: state_q <= (t_q == word_t'(1)) ? S_FIN : S_SQ;
        S_SQ: begin
          if (!wait_q && !need) state_q <= S_CSQ;
          else if (pw_done && (i_q + CntBits'(1) >= m_q)) state_q <= S_FIN;
        end
        S_CSQ:  if (!wait_q && !need) state_q <= S_CC;
        S_CC:   if (pw_done) state_q <= S_CT;
        S_CT:   if (pw_done) state_q <= S_CR;
        S_CR:   if (pw_done) state_q <= S_LOOP;
        S_FIN: begin
          if (!out_v_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        p_q    <= s_axis_tdata_i[63:32];
        dvd_q  <= s_axis_tdata_i[31:0];
        n_q    <= '0;
        cnt_q  <= '0;
        ok_q   <= (s_axis_tdata_i[63:32] >= 32'd2);
        root_q <= (s_axis_tdata_i[63:32] == 32'd2) ? {31'd0, s_axis_tdata_i[0]} : '0;
      end
      S_RED: begin
        n_q   <= tmp_rem;
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + CntBits'(1);
      end
      S_EUL: begin
        if (pw_done) begin
          ok_q <= (pw_res == word_t'(1));
          q_q  <= p_q - word_t'(1);
          s_q  <= '0;
        end
      end
      S_P34: if (pw_done) root_q <= pw_res;
      S_FACT: begin
        if (!q_q[0]) begin
          q_q <= q_q >> 1;
          s_q <= s_q + CntBits'(1);
        end
        z_q     <= word_t'(2);
        tried_q <= '0;
        c_q     <= '0;
      end
      S_ZPOW: begin
        if (pw_done && pw_res != p_q - word_t'(1)) begin
          z_q     <= z_q + word_t'(1);
          tried_q <= tried_q + TriedBits'(1);
        end
      end
      S_CPOW: if (pw_done) c_q <= pw_res;
      S_TPOW: if (pw_done) t_q <= pw_res;
      S_RPOW: begin
        if (pw_done) begin
          r_q <= pw_res;
          m_q <= s_q;
        end
      end
      S_LOOP: begin
        root_q <= r_q;
        i_q    <= '0;
        b_q    <= t_q;
      end
      S_SQ: begin
        if (!wait_q && !need) begin
          b_q <= c_q;
          j_q <= '0;
        end else if (pw_done) begin
          b_q <= pw_res;
          i_q <= i_q + CntBits'(1);
          if (i_q + CntBits'(1) >= m_q) ok_q <= 1'b0;
        end
      end
      S_CSQ: begin
        if (pw_done) begin
          b_q <= pw_res;
          j_q <= j_q + CntBits'(1);
        end
      end
      S_CC: begin
        if (pw_done) begin
          c_q <= pw_res;
          m_q <= i_q;
        end
      end
      S_CT: if (pw_done) t_q <= pw_res;
      S_CR: if (pw_done) r_q <= pw_res;
      S_FIN: begin
        if (!out_v_q || m_axis_tready_i) begin
          out_ok_q   <= ok_q;
          out_root_q <= ok_q ? root_q : '0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ tb/sv/modular_square_root_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for modular_square_root_unit: stream driver, stream monitor
// and a square root predictor that runs alongside. Depends on msr_pkg and the unit.
module modular_square_root_unit_test;
  import msr_pkg::*;

  typedef struct {
    word_t value;
    word_t modulus;
  } sqrt_req_t;

  typedef struct {
    word_t root;
    logic  has_root;
  } sqrt_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;  // value [31:0], modulus [63:32]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // root [31:0]
  logic        m_axis_tuser_o;        // has_root [0]

  sqrt_req_t pending_reqs[$];
  sqrt_res_t expected_roots[$];
  int        mismatches = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        roots_found = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_cycles = 0;
  bit        hold_done = 1'b0;

  modular_square_root_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    b = b % p;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, p);
      b = mul_mod(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic sqrt_res_t predict_root(word_t value, word_t modulus);
    sqrt_res_t       res;
    longint unsigned n, p, q, half, z, c, t, r, b;
    int unsigned     s, m, i, j, tried;
    bit              done;
    n = value;
    p = modulus;
    res.root = '0;
    res.has_root = 1'b0;
    if (p < 2) begin
      res.has_root = 1'b0;
    end else if (p == 2) begin
      res.root = word_t'(n & 1);
      res.has_root = 1'b1;
    end else begin
      n = n % p;
      if (n == 0) begin
        res.has_root = 1'b1;
      end else if (pow_mod(n, (p - 1) >> 1, p) != 1) begin
        res.has_root = 1'b0;
      end else if ((p & 3) == 3) begin
        res.root = word_t'(pow_mod(n, (p >> 2) + 1, p));
        res.has_root = 1'b1;
      end else begin
        q = p - 1;
        half = (p - 1) >> 1;
        s = 0;
        c = 0;
        tried = 0;
        while (q[0] == 1'b0) begin
          q = q >> 1;
          s++;
        end
        for (z = 2; z < p && tried < SearchLimit; z++) begin
          if (pow_mod(z, half, p) == p - 1) begin
            c = pow_mod(z, q, p);
            break;
          end
          tried++;
        end
        t = pow_mod(n, q, p);
        r = pow_mod(n, (q >> 1) + 1, p);
        m = s;
        done = 1'b0;
        while (!done) begin
          if (t == 1) begin
            res.root = word_t'(r);
            res.has_root = 1'b1;
            done = 1'b1;
          end else begin
            i = 0;
            b = t;
            while (b != 1 && !done) begin
              b = mul_mod(b, b, p);
              i++;
              if (i >= m) done = 1'b1;
            end
            if (!done) begin
              b = c;
              for (j = 0; j + 1 + i < m; j++) b = mul_mod(b, b, p);
              m = i;
              c = mul_mod(b, b, p);
              t = mul_mod(t, c, p);
              r = mul_mod(r, b, p);
            end
          end
        end
      end
    end
    if (!res.has_root) res.root = '0;
    return res;
  endfunction

  function automatic bit prime_check(int unsigned x);
    if (x < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= x; d++) if (x % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic word_t next_prime(int unsigned x);
    while (!prime_check(x)) x++;
    return word_t'(x);
  endfunction

  function automatic int draw_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic add_req(word_t value, word_t modulus);
    sqrt_req_t req;
    req.value = value;
    req.modulus = modulus;
    pending_reqs.push_back(req);
  endtask

  // Driver: capture the prediction on each accepted beat, then offer the next item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_roots.push_back(predict_root(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]));
        beats_in++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          sqrt_req_t req;
          req = pending_reqs.pop_front();
          s_axis_tdata_i <= {req.modulus, req.value};
          s_axis_tvalid_i <= 1'b1;
          send_gap <= draw_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction; stall at random, and hold once after the 40th result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        beats_out++;
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with no item pending: root %h flag %b",
                                         m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          sqrt_res_t exp_res;
          exp_res = expected_roots.pop_front();
          if (exp_res.has_root) roots_found++;
          if (m_axis_tdata_o !== exp_res.root || m_axis_tuser_o !== exp_res.has_root) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected root %h flag %b, got root %h flag %b",
                       beats_out, exp_res.root, exp_res.has_root, m_axis_tdata_o,
                       m_axis_tuser_o);
          end
        end
      end
      if (!hold_done && beats_out == 40) begin
        hold_done <= 1'b1;
        hold_cycles <= 30000;
        m_axis_tready_i <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (m_axis_tvalid_o && m_axis_tready_i) recv_gap <= draw_gap();
      end
    end
  end

  initial begin
    word_t p, r;
    int    sel;
    // directed corners
    add_req(32'd0, 32'd0);
    add_req(32'hFFFF_FFFF, 32'd1);
    add_req(32'd7, 32'd2);
    add_req(32'hFFFF_FFFE, 32'd2);
    add_req(32'd0, 32'd4294967291);
    add_req(32'd4294967291, 32'd4294967291);
    add_req(32'hFFFF_FFFF, 32'd4294967291);
    add_req(32'd2, 32'd3);
    add_req(32'd4, 32'd5);
    add_req(32'd2, 32'd5);
    add_req(32'd13, 32'd17);
    add_req(32'd3, 32'd17);
    add_req(32'd49, 32'd3221225473);
    add_req(32'd5, 32'd3221225473);
    add_req(32'h1234_5678, 32'd4294967197);
    add_req(32'd16, 32'd2013265921);
    add_req(32'd1, 32'd4);
    add_req(32'd4, 32'd9);
    add_req(32'd4, 32'd15);
    add_req(32'd11, 32'd21);
    add_req(32'd24, 32'd25);
    add_req(32'd9, 32'd65);
    add_req(32'd17, 32'hFFFF_FFFF);
    add_req(32'h8000_0000, 32'd4294967279);
    // random part: mostly residues of primes, some non-residues, composites and corners
    for (int k = 0; k < 300; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) p = next_prime($urandom_range(3, 65535));
      else if (sel < 65) p = next_prime($urandom_range(3, 255));
      else if (sel < 80) p = 32'($urandom() | 3);
      else if (sel < 88) begin
        case ($urandom_range(0, 4))
          0: p = 32'd4294967291;
          1: p = 32'd4294967197;
          2: p = 32'd3221225473;
          3: p = 32'd2013265921;
          default: p = 32'd4294967189;
        endcase
      end else if (sel < 96) p = 32'($urandom_range(3, 200));
      else p = 32'($urandom_range(0, 2));
      if (p > 2 && $urandom_range(0, 99) < 65) begin
        r = 32'($urandom());
        add_req(32'(mul_mod(r, r, p) + p * $urandom_range(0, 3)), p);
      end else begin
        add_req(32'($urandom()), p);
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !s_axis_tvalid_i && expected_roots.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d items sent, %0d results checked, %0d with a root",
             beats_in, beats_out, roots_found);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_roots.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results outstanding", expected_roots.size());
    $display("Mismatches found");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/msr_pkg.sv
hw/rtl/msr_modmul.sv
hw/rtl/msr_pow.sv
hw/rtl/modular_square_root_unit.sv
tb/sv/modular_square_root_unit_test.sv
